### hdl/htfp_pkg.sv
// shared types, constants and the hex digit decoder of the telemetry frame parser
// no dependencies; imported by every module of the block except htfp_digit_cell
`default_nettype none

package htfp_pkg;

    localparam logic [7:0] START_MARK = 8'h40;
    localparam logic [7:0] END_MARK   = 8'h0D;
    localparam logic [7:0] NUL_BYTE   = 8'h00;
    localparam int         COUNT_W    = 5;
    localparam logic [COUNT_W-1:0] FULL_COUNT = 5'd26;
    localparam int         NUM_DIGITS = 25;
    localparam int         OUT_DATA_W = 104;

    typedef enum logic {
        ST_IDLE,
        ST_FRAME
    } frame_state_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_OTHER_DESC = 2'd1,
        STATUS_BAD_LENGTH = 2'd2,
        STATUS_BAD_HEX    = 2'd3
    } frame_status_t;

    typedef struct packed {
        logic          shift_en;
        logic [3:0]    nibble;
        logic          frame_end;
        frame_status_t status;
    } htfp_ctrl_t;

    // returns {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/hex_telemetry_frame_parser.sv
// top level of the hex telemetry frame parser: sequencer, 25-cell digit chain, result register
// depends on htfp_pkg, htfp_frame_ctrl and htfp_digit_cell
//
//  channel  | dir | tdata                         | tuser
//  s_       | in  | rx_byte [7:0]                 | -
//  m_       | out | raw fields, 104 bits          | frame_status [1:0]
//  cfg_wr_  | in  | sensor_descriptor [7:0]       | -
//
// one input byte per cycle while s_tready is high; each digit shifts the chain by one cell
// the result appears in the cycle after the accepted carriage return
// s_tready drops only while a result waits and m_tready is low
// aresetn clears sequencer, descriptor register and the result valid flag
`default_nettype none

module hex_telemetry_frame_parser
    import htfp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // rx_byte
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // engine_speed, manifold_pressure_raw, supply_voltage_raw, coolant_temp_raw,
    // advance_angle_raw, intake_flow_index, idle_valve_state, throttle_switch_state,
    // gas_valve_state, zero fill
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic [1:0]                 m_tuser,   // frame_status
    input  wire logic                  cfg_wr_en,
    input  wire logic [7:0]            cfg_wr_data
);

    htfp_ctrl_t ctrl;
    logic       byte_accept;
    logic [3:0] cell_q [NUM_DIGITS];

    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [1:0]            m_user_reg;
    logic [99:0]           fields;

    assign s_tready    = !m_valid_reg || m_tready;
    assign byte_accept = s_tvalid && s_tready;

    htfp_frame_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ctrl        (ctrl)
    );

    for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
        if (i == 0) begin : g_head
            htfp_digit_cell u_cell (
                .aclk       (aclk),
                .shift_en   (ctrl.shift_en),
                .nibble_in  (ctrl.nibble),
                .nibble_out (cell_q[i])
            );
        end else begin : g_body
            htfp_digit_cell u_cell (
                .aclk       (aclk),
                .shift_en   (ctrl.shift_en),
                .nibble_in  (cell_q[i-1]),
                .nibble_out (cell_q[i])
            );
        end
    end

    // oldest digit sits in the last cell
    assign fields = {cell_q[0], cell_q[1], cell_q[2],
                     cell_q[4], cell_q[3],
                     cell_q[8], cell_q[7], cell_q[6], cell_q[5],
                     cell_q[12], cell_q[11], cell_q[10], cell_q[9],
                     cell_q[16], cell_q[15], cell_q[14], cell_q[13],
                     cell_q[20], cell_q[19], cell_q[18], cell_q[17],
                     cell_q[24], cell_q[23], cell_q[22], cell_q[21]};

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.frame_end) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.frame_end) begin
            m_user_reg <= ctrl.status;
            if (ctrl.status == STATUS_OK) begin
                m_data_reg <= {4'd0, fields};
            end else begin
                m_data_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

### hdl/htfp_digit_cell.sv
// one cell of the digit chain: holds one hex nibble, passes it on when shifted
// depends on nothing but the clock
`default_nettype none

module htfp_digit_cell (
    input  wire logic       aclk,
    input  wire logic       shift_en,
    input  wire logic [3:0] nibble_in,
    output logic      [3:0] nibble_out
);

    logic [3:0] nibble_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            nibble_reg <= nibble_in;
        end
    end

    assign nibble_out = nibble_reg;

endmodule

`default_nettype wire

### hdl/htfp_frame_ctrl.sv
// frame sequencer: start and end marks, byte count, descriptor, error flags, status
// depends on htfp_pkg
`default_nettype none

module htfp_frame_ctrl
    import htfp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       byte_accept,
    input  wire logic [7:0] rx_byte,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    output htfp_ctrl_t      ctrl
);

    frame_state_t       state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         desc_reg, desc_next;
    logic               len_err_reg, len_err_next;
    logic               hex_err_reg, hex_err_next;
    logic [7:0]         sensor_desc_reg;

    logic       live;
    logic       is_end;
    logic [4:0] hex;
    logic [7:0] desc_eff;

    assign live   = byte_accept && (rx_byte != NUL_BYTE);
    assign is_end = (rx_byte == END_MARK);
    assign hex    = hex_value(rx_byte);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            desc_reg        <= '0;
            len_err_reg     <= 1'b0;
            hex_err_reg     <= 1'b0;
            sensor_desc_reg <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            desc_reg    <= desc_next;
            len_err_reg <= len_err_next;
            hex_err_reg <= hex_err_next;
            if (cfg_wr_en) begin
                sensor_desc_reg <= cfg_wr_data;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        if (live) begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (rx_byte == START_MARK) begin
                        state_next = ST_FRAME;
                    end
                end
                ST_FRAME: begin
                    if (is_end) begin
                        state_next = ST_IDLE;
                    end
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    always_comb begin
        count_next   = count_reg;
        desc_next    = desc_reg;
        len_err_next = len_err_reg;
        hex_err_next = hex_err_reg;
        if (live) begin
            if (state_reg == ST_IDLE) begin
                if (rx_byte == START_MARK) begin
                    count_next   = '0;
                    desc_next    = '0;
                    len_err_next = 1'b0;
                    hex_err_next = 1'b0;
                end
            end else if (is_end) begin
                count_next = '0;
            end else if (count_reg >= FULL_COUNT) begin
                len_err_next = 1'b1;
            end else begin
                if (count_reg == '0) begin
                    desc_next = rx_byte;
                end else if (!hex[4]) begin
                    hex_err_next = 1'b1;
                end
                count_next = count_reg + 1'b1;
            end
        end
    end

    assign desc_eff = (count_reg == '0) ? END_MARK : desc_reg;

    always_comb begin
        ctrl.nibble    = hex[3:0];
        ctrl.shift_en  = live && (state_reg == ST_FRAME) && !is_end
                         && (count_reg != '0) && (count_reg < FULL_COUNT);
        ctrl.frame_end = live && (state_reg == ST_FRAME) && is_end;
        priority if (desc_eff != sensor_desc_reg) begin
            ctrl.status = STATUS_OTHER_DESC;
        end else if (len_err_reg || (count_reg != FULL_COUNT)) begin
            ctrl.status = STATUS_BAD_LENGTH;
        end else if (hex_err_reg) begin
            ctrl.status = STATUS_BAD_HEX;
        end else begin
            ctrl.status = STATUS_OK;
        end
    end

endmodule

`default_nettype wire

### hdl/htfp_checker.sv
// port-level checks on the hex telemetry frame parser, bound to the top level
// depends on htfp_pkg and hex_telemetry_frame_parser
`default_nettype none

module htfp_checker
    import htfp_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic [1:0]            m_tuser
);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    a_error_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STATUS_OK) |-> (m_tdata == '0))
        else $error("raw fields not cleared on error status");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind hex_telemetry_frame_parser htfp_checker u_htfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### tb/sv/hex_telemetry_frame_parser_tb.sv
// self-checking testbench for hex_telemetry_frame_parser: a directed table of frames, then
// random frames and noise, each result checked against a behavioural frame decoder
// depends on htfp_pkg and the hex_telemetry_frame_parser rtl
`timescale 1ns / 1ps

module hex_telemetry_frame_parser_tb;
    import htfp_pkg::*;

    localparam int    QUIET_LIMIT   = 4000;
    localparam int    PHASE_BYTES   = 225;
    localparam string HEX_CHARS     = "0123456789ABCDEFabcdef";

    typedef struct packed {
        logic [3:0]  fill;
        logic [3:0]  gas_valve;
        logic [3:0]  throttle_switch;
        logic [3:0]  idle_valve;
        logic [7:0]  intake_flow;
        logic [15:0] advance_angle;
        logic [15:0] coolant_temp;
        logic [15:0] supply_voltage;
        logic [15:0] manifold_pressure;
        logic [15:0] engine_speed;
    } telemetry_t;

    typedef struct packed {
        frame_status_t status;
        telemetry_t    raw;
    } frame_result_t;

    typedef struct {
        string bytes;
        int    desc_cfg;
        int    want_status;
    } frame_row_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata     = 8'h00;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_wr_en   = 1'b0;
    logic [7:0]            cfg_wr_data = 8'h00;

    // decoder state
    logic [7:0]  sensor_desc = 8'h00;
    bit          pf_in_frame = 1'b0;
    logic [4:0]  pf_count    = '0;
    logic [7:0]  pf_desc     = 8'h00;
    bit          pf_len_err  = 1'b0;
    bit          pf_hex_err  = 1'b0;
    logic [15:0] pf_wide [5] = '{default: '0};
    logic [7:0]  pf_byte     = 8'h00;
    logic [3:0]  pf_flags [3] = '{default: '0};

    frame_result_t expected_frames[$];
    frame_row_t    frame_rows[];
    int            fail_count   = 0;
    int            quiet_cycles = 0;
    int            gap_pct      = 0;
    int            stall_pct    = 0;
    int            stall_left   = 0;
    int            bytes_sent   = 0;

    hex_telemetry_frame_parser dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int pick_len();
        if ($urandom_range(9) == 0) begin
            return $urandom_range(10, 50);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
        v = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
            return 1'b1;
        end
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = c[3:0] + 4'd9;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // advances the decoder by one byte; returns 1 when a frame ends
    function automatic bit parse_byte(input logic [7:0] c, output frame_result_t r);
        logic [3:0] nib;
        int         pos;
        r = '0;
        if (c == NUL_BYTE) begin
            return 1'b0;
        end
        if (!pf_in_frame) begin
            if (c == START_MARK) begin
                pf_in_frame = 1'b1;
                pf_count    = '0;
                pf_desc     = 8'h00;
                pf_len_err  = 1'b0;
                pf_hex_err  = 1'b0;
            end
            return 1'b0;
        end
        if (c == END_MARK) begin
            if (pf_count == 0) begin
                pf_desc = END_MARK;
            end
            if (pf_desc != sensor_desc) begin
                r.status = STATUS_OTHER_DESC;
            end else if (pf_len_err || pf_count != FULL_COUNT) begin
                r.status = STATUS_BAD_LENGTH;
            end else if (pf_hex_err) begin
                r.status = STATUS_BAD_HEX;
            end else begin
                r.status                = STATUS_OK;
                r.raw.engine_speed      = pf_wide[0];
                r.raw.manifold_pressure = pf_wide[1];
                r.raw.supply_voltage    = pf_wide[2];
                r.raw.coolant_temp      = pf_wide[3];
                r.raw.advance_angle     = pf_wide[4];
                r.raw.intake_flow       = pf_byte;
                r.raw.idle_valve        = pf_flags[0];
                r.raw.throttle_switch   = pf_flags[1];
                r.raw.gas_valve         = pf_flags[2];
            end
            pf_in_frame = 1'b0;
            pf_count    = '0;
            return 1'b1;
        end
        if (pf_count >= FULL_COUNT) begin
            pf_len_err = 1'b1;
            return 1'b0;
        end
        if (pf_count == 0) begin
            pf_desc = c;
        end else begin
            pos = int'(pf_count) - 1;
            if (!hex_digit(c, nib)) begin
                pf_hex_err = 1'b1;
            end else if (pos < 20) begin
                pf_wide[pos / 4] = {pf_wide[pos / 4][11:0], nib};
            end else if (pos < 22) begin
                pf_byte = {pf_byte[3:0], nib};
            end else if (pos < 25) begin
                pf_flags[pos - 22] = nib;
            end
        end
        pf_count = pf_count + 5'd1;
        return 1'b0;
    endfunction

    // one byte transaction; a non-negative want_status overrides the decoded status
    task automatic send_byte(input logic [7:0] c, input int want_status);
        frame_result_t r;
        int            gap;
        gap = ($urandom_range(99) < gap_pct) ? pick_len() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (parse_byte(c, r)) begin
            if (want_status >= 0) begin
                r        = '0;
                r.status = frame_status_t'(want_status);
            end
            expected_frames = {expected_frames, r};
        end
        bytes_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_desc(input logic [7:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sensor_desc  = v;
    endtask

    task automatic send_random_frame();
        int         kind;
        int         n;
        logic [7:0] d;
        kind = $urandom_range(99);
        if (kind < 85) begin
            send_byte(START_MARK, -1);
            d = ($urandom_range(7) == 0) ? 8'($urandom) : sensor_desc;
            send_byte(d, -1);
            n = (kind < 70) ? NUM_DIGITS : $urandom_range(0, 32);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(24) == 0) begin
                    send_byte(NUL_BYTE, -1);
                end
                if (kind >= 70 && $urandom_range(9) == 0) begin
                    send_byte(8'($urandom), -1);
                end else begin
                    send_byte(HEX_CHARS[$urandom_range(21)], -1);
                end
            end
            send_byte(END_MARK, -1);
        end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom), -1);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    // result sink with random back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if ($urandom_range(99) < stall_pct) begin
            stall_left = pick_len();
        end
        m_tready <= aresetn && (stall_left == 0);
    end

    always @(posedge aclk) begin
        frame_result_t want;
        telemetry_t    got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_frames.size() == 0) begin
                fail_count++;
                $display("%0t ns: result expected none actual status %0d data %h",
                         $time, m_tuser, m_tdata);
            end else begin
                want = expected_frames.pop_front();
                check_field("frame_status", 16'(want.status), 16'(m_tuser));
                check_field("engine_speed", want.raw.engine_speed, got.engine_speed);
                check_field("manifold_pressure_raw", want.raw.manifold_pressure,
                            got.manifold_pressure);
                check_field("supply_voltage_raw", want.raw.supply_voltage,
                            got.supply_voltage);
                check_field("coolant_temp_raw", want.raw.coolant_temp, got.coolant_temp);
                check_field("advance_angle_raw", want.raw.advance_angle,
                            got.advance_angle);
                check_field("intake_flow_index", 16'(want.raw.intake_flow),
                            16'(got.intake_flow));
                check_field("idle_valve_state", 16'(want.raw.idle_valve),
                            16'(got.idle_valve));
                check_field("throttle_switch_state", 16'(want.raw.throttle_switch),
                            16'(got.throttle_switch));
                check_field("gas_valve_state", 16'(want.raw.gas_valve),
                            16'(got.gas_valve));
                check_field("zero fill", 16'(want.raw.fill), 16'(got.fill));
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t ns: no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] phase_desc [7];
        logic [7:0] c;
        int         phase_end;
        phase_desc = '{8'h00, 8'hFF, 8'h0D, 8'h40, 8'($urandom), 8'($urandom), 8'h53};
        frame_rows = '{
            '{"@S0123456789ABCDEFabcdef012\r", -1, STATUS_OTHER_DESC},
            '{"hello\r ~\377", 8'h53, -1},
            '{"@S0000000000000000000000000\r", -1, -1},
            '{"@SFFFFFFFFFFFFFFFFFFFFFFFFF\r", -1, -1},
            '{"@Sfffffffffffffffffffffffff\r", -1, -1},
            '{"@S^0123^456789ABCDEFabcdef012^\r", -1, -1},
            '{"@S0123456789ABCDEFabcdef01\r", -1, STATUS_BAD_LENGTH},
            '{"@S0123456789ABCDEFabcdef0123\r", -1, STATUS_BAD_LENGTH},
            '{"@S0123456789ABCDEFabcdef0123456789ABCDEF\r", -1, STATUS_BAD_LENGTH},
            '{"@S0123/:@G`g89ABCDEFabcdef0\r", -1, STATUS_BAD_HEX},
            '{"@T0123456789ABCDEFabcdef012\r", -1, STATUS_OTHER_DESC},
            '{"@T12\r", -1, STATUS_OTHER_DESC},
            '{"@S12G\r", -1, STATUS_BAD_LENGTH},
            '{"@\r", -1, STATUS_OTHER_DESC},
            '{"@\r", 8'h0D, STATUS_BAD_LENGTH},
            '{"@@0123456789ABCDEFabcdef012\r", 8'h40, -1},
            '{"@\377FFFFFFFFFFFFFFFFFFFFFFFFF\r", 8'hFF, -1},
            '{"@A0123456789ABCDEFabcdef012\r", 8'h00, STATUS_OTHER_DESC}
        };
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        gap_pct   = 20;
        stall_pct = 20;
        foreach (frame_rows[r]) begin
            if (frame_rows[r].desc_cfg >= 0) begin
                write_desc(8'(frame_rows[r].desc_cfg));
            end
            for (int i = 0; i < frame_rows[r].bytes.len(); i++) begin
                c = frame_rows[r].bytes[i];
                if (c == "^") begin
                    c = NUL_BYTE;
                end
                send_byte(c, frame_rows[r].want_status);
            end
        end

        foreach (phase_desc[p]) begin
            write_desc(phase_desc[p]);
            gap_pct   = (p == 2) ? 0 : $urandom_range(5, 40);
            stall_pct = (p == 2) ? 0 : $urandom_range(5, 40);
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end) send_random_frame();
            // close any frame left open by noise
            send_byte(END_MARK, -1);
        end

        drain();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
